FILE: src/dit_pkg.sv
// ---------------------------------------------------------------------------
// dit_pkg: shared types and constants for the dual interval timer block.
// Item formats, function codes, bus register addresses and the per-timer
// control group passed from the top level to each timer unit.
// ---------------------------------------------------------------------------
package dit_pkg;

    // Function codes carried in each input item.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Bus register addresses.
    localparam logic [3:0] ADDR_A_LO   = 4'h4;
    localparam logic [3:0] ADDR_A_HI   = 4'h5;
    localparam logic [3:0] ADDR_B_LO   = 4'h6;
    localparam logic [3:0] ADDR_B_HI   = 4'h7;
    localparam logic [3:0] ADDR_ICR    = 4'hd;
    localparam logic [3:0] ADDR_CTRL_A = 4'he;
    localparam logic [3:0] ADDR_CTRL_B = 4'hf;

    // Bit positions inside the control and interrupt control bytes.
    localparam int CTRL_RUN_BIT   = 0;
    localparam int CTRL_LOAD_BIT  = 4;
    localparam int CTRL_SRC_LSB   = 5;
    localparam int ICR_SEL_A_BIT  = 0;
    localparam int ICR_SEL_B_BIT  = 1;
    localparam int ICR_SET_BIT    = 7;

    // Configuration register indexes.
    localparam logic CFG_FIRST_ONE_SHOT  = 1'b0;
    localparam logic CFG_SECOND_ONE_SHOT = 1'b1;

    localparam int CountWidth = 16;

    // One input item.
    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  reg_addr;
        logic [7:0]  write_data;
        logic [15:0] elapsed_cycles;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pulse;
    } t_out_item;

    // Decoded strobes for one timer, valid for a single cycle.
    typedef struct packed {
        logic tick;       // advance by the elapsed cycles
        logic wr_lat_lo;  // load the latch low byte
        logic wr_lat_hi;  // load the latch high byte
        logic wr_ctrl;    // write the control byte
        logic wr_ien;     // update the interrupt enable
        logic ien_val;    // new interrupt enable value
        logic src_off;    // new source is not processor cycles
    } t_tmr_ctl;

endpackage

FILE: src/dit_timer.sv
// ---------------------------------------------------------------------------
// dit_timer: one 16-bit down-counting interval timer.
// Holds latch, count, run, source, interrupt enable and underflow flag, and
// applies one decoded bus write or tick per cycle.
// ---------------------------------------------------------------------------
module dit_timer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dit_pkg::t_tmr_ctl    i_ctl,
    input  logic [7:0]           i_wdata,
    input  logic [15:0]          i_elapsed,
    input  logic                 i_one_shot,
    output logic [15:0]          o_count,
    output logic                 o_flag,
    output logic                 o_irq
);
    import dit_pkg::*;

    logic [CountWidth-1:0] r_latch, n_latch;
    logic [CountWidth-1:0] r_count, n_count;
    logic                  r_running, n_running;
    logic                  r_src_off, n_src_off;
    logic                  r_ien, n_ien;
    logic                  r_flag, n_flag;
    logic                  underflow;

    // A counting timer underflows when the elapsed cycles reach the count.
    assign underflow = i_ctl.tick && r_running && !r_src_off && (i_elapsed >= r_count);

    // Next-state logic for writes and ticks.
    always_comb begin
        n_latch   = r_latch;
        n_count   = r_count;
        n_running = r_running;
        n_src_off = r_src_off;
        n_ien     = r_ien;
        n_flag    = r_flag;
        if (i_ctl.wr_lat_lo) begin
            n_latch[7:0] = i_wdata;
        end
        if (i_ctl.wr_lat_hi) begin
            n_latch[15:8] = i_wdata;
        end
        if (i_ctl.wr_ien) begin
            n_ien = i_ctl.ien_val;
        end
        if (i_ctl.wr_ctrl) begin
            n_running = i_wdata[CTRL_RUN_BIT];
            n_src_off = i_ctl.src_off;
            if (i_wdata[CTRL_LOAD_BIT]) begin
                n_count = r_latch;
            end
        end
        if (underflow) begin
            n_flag = 1'b1;
            if (i_one_shot) begin
                n_running = 1'b0;
                n_count   = '0;
            end else begin
                n_count = r_latch;
            end
        end else if (i_ctl.tick && r_running && !r_src_off) begin
            n_count = r_count - i_elapsed;
        end
    end

    // Timer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch   <= '0;
            r_count   <= '0;
            r_running <= 1'b0;
            r_src_off <= 1'b0;
            r_ien     <= 1'b0;
            r_flag    <= 1'b0;
        end else begin
            r_latch   <= n_latch;
            r_count   <= n_count;
            r_running <= n_running;
            r_src_off <= n_src_off;
            r_ien     <= n_ien;
            r_flag    <= n_flag;
        end
    end

    assign o_count = r_count;
    assign o_flag  = r_flag;
    assign o_irq   = underflow && r_ien;

    // The underflow flag is sticky once set.
    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flag |=> r_flag)
        else $error("timer flag cleared");

    // The count only moves on a tick or a control write.
    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_ctl.tick && !i_ctl.wr_ctrl) |=> $stable(r_count))
        else $error("count changed without a tick or control write");

    // A one-shot underflow stops the timer at zero.
    a_one_shot_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (underflow && i_one_shot && !i_ctl.wr_ctrl) |=> (!r_running && r_count == '0))
        else $error("one-shot timer did not stop");

endmodule

FILE: src/dual_interval_timer_regs.sv
// ---------------------------------------------------------------------------
// dual_interval_timer_regs: two 16-bit interval timers behind a byte bus.
//
// Input channel (i_valid, o_stall, i_data): each transaction is a register
// write, a register read or a tick carrying elapsed processor cycles.
// Output channel (o_valid, i_stall, o_data): exactly one result per input
// transaction, in order, holding the read byte and the interrupt pulse.
// Configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) sets the one-shot
// mode of each timer; write it only while the block is idle.
//
// A transaction taken into the input register is decoded, updates the
// timers and is then registered into the result register, which drives
// o_valid. Throughput is one transaction per cycle while the output is not
// stalled; both stages advance whenever the result register is empty or
// being taken. An output stall holds the result and a full input register
// and backs up onto o_stall; a stalled result holds its value.
// Synchronous reset clears both stages, all timer state and configuration.
// ---------------------------------------------------------------------------
module dual_interval_timer_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dit_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output dit_pkg::t_out_item o_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic               i_cfg_data
);
    import dit_pkg::*;

    logic      r_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      s1_adv;
    logic      r_one_shot_a, r_one_shot_b;
    t_tmr_ctl  ctl_a, ctl_b;
    logic [15:0] count_a, count_b;
    logic      flag_a, flag_b, irq_a, irq_b;
    logic      do_write, do_read, do_tick;

    // Handshake: stage one moves when the result register can take it.
    assign s1_adv  = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_adv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_shot_a <= 1'b0;
            r_one_shot_b <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_ONE_SHOT:  r_one_shot_a <= i_cfg_data;
                CFG_SECOND_ONE_SHOT: r_one_shot_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_s1 <= i_data;
        end
    end

    // Decode the item in the input register into per-timer strobes.
    assign do_write = r_s1_valid && s1_adv && (r_s1.func == FUNC_WRITE);
    assign do_read  = r_s1.func == FUNC_READ;
    assign do_tick  = r_s1_valid && s1_adv && (r_s1.func == FUNC_TICK);

    always_comb begin
        ctl_a           = '0;
        ctl_b           = '0;
        ctl_a.tick      = do_tick;
        ctl_b.tick      = do_tick;
        ctl_a.wr_lat_lo = do_write && (r_s1.reg_addr == ADDR_A_LO);
        ctl_a.wr_lat_hi = do_write && (r_s1.reg_addr == ADDR_A_HI);
        ctl_b.wr_lat_lo = do_write && (r_s1.reg_addr == ADDR_B_LO);
        ctl_b.wr_lat_hi = do_write && (r_s1.reg_addr == ADDR_B_HI);
        ctl_a.wr_ien    = do_write && (r_s1.reg_addr == ADDR_ICR)
                          && r_s1.write_data[ICR_SEL_A_BIT];
        ctl_b.wr_ien    = do_write && (r_s1.reg_addr == ADDR_ICR)
                          && r_s1.write_data[ICR_SEL_B_BIT];
        ctl_a.ien_val   = r_s1.write_data[ICR_SET_BIT];
        ctl_b.ien_val   = r_s1.write_data[ICR_SET_BIT];
        ctl_a.wr_ctrl   = do_write && (r_s1.reg_addr == ADDR_CTRL_A);
        ctl_b.wr_ctrl   = do_write && (r_s1.reg_addr == ADDR_CTRL_B);
        // Timer A has a one-bit source field, timer B a two-bit one.
        ctl_a.src_off   = r_s1.write_data[CTRL_SRC_LSB];
        ctl_b.src_off   = |r_s1.write_data[CTRL_SRC_LSB+1:CTRL_SRC_LSB];
    end

    dit_timer u_timer_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl_a),
        .i_wdata    (r_s1.write_data),
        .i_elapsed  (r_s1.elapsed_cycles),
        .i_one_shot (r_one_shot_a),
        .o_count    (count_a),
        .o_flag     (flag_a),
        .o_irq      (irq_a)
    );

    dit_timer u_timer_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl_b),
        .i_wdata    (r_s1.write_data),
        .i_elapsed  (r_s1.elapsed_cycles),
        .i_one_shot (r_one_shot_b),
        .o_count    (count_b),
        .o_flag     (flag_b),
        .o_irq      (irq_b)
    );

    // Result: read mux and combined interrupt pulse.
    always_comb begin
        n_out           = '0;
        n_out.irq_pulse = (r_s1.func == FUNC_TICK) && (irq_a || irq_b);
        if (do_read) begin
            unique case (r_s1.reg_addr)
                ADDR_A_LO: n_out.read_data = count_a[7:0];
                ADDR_A_HI: n_out.read_data = count_a[15:8];
                ADDR_B_LO: n_out.read_data = count_b[7:0];
                ADDR_B_HI: n_out.read_data = count_b[15:8];
                ADDR_ICR:  n_out.read_data = {6'd0, flag_b, flag_a};
                default:   n_out.read_data = '0;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Every item leaving the input register produces a result.
    a_item_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv) |=> r_out_valid)
        else $error("item lost between stages");

    // Only ticks raise the interrupt pulse.
    a_irq_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv && r_s1.func != FUNC_TICK) |=> !r_out.irq_pulse)
        else $error("interrupt pulse outside a tick");

    // Only reads return a nonzero byte.
    a_data_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv && r_s1.func != FUNC_READ) |=> (r_out.read_data == '0))
        else $error("read data outside a read");

endmodule

FILE: tb/sv/dual_interval_timer_regs_tb.sv
// ---------------------------------------------------------------------------
// dual_interval_timer_regs_tb: self-checking bench for the dual timer block.
// A behavioral copy of both timers and the byte bus predicts the read byte
// and the interrupt pulse for every accepted transaction. Each phase sets the
// one-shot modes first, then runs random bus traffic and ticks with random
// idle cycles and output stalls, except for the calm third phase. The first
// phase starts with directed traffic.
// ---------------------------------------------------------------------------
module dual_interval_timer_regs_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dit_pkg::*;

    // The function code that the block must ignore.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // A bus address that maps to no register.
    localparam logic [3:0] ADDR_UNUSED = 4'h3;

    // Behavioral copy of the two timers; index 0 is timer A, index 1 timer B.
    class timer_regs_model;
        logic [15:0] latch [2];
        logic [15:0] count [2];
        logic        running [2];
        logic        irq_en [2];
        logic        flag [2];
        logic [1:0]  source [2];
        logic        one_shot [2];
        t_out_item   expected_replies [$];
        int          fails;

        function new();
            for (int t = 0; t < 2; t++) begin
                latch[t]    = '0;
                count[t]    = '0;
                running[t]  = 1'b0;
                irq_en[t]   = 1'b0;
                flag[t]     = 1'b0;
                source[t]   = '0;
                one_shot[t] = 1'b0;
            end
            fails = 0;
        endfunction

        // Count one timer down; returns one on an underflow with interrupts on.
        function logic advance(int t, logic [15:0] elapsed);
            if (!running[t] || source[t] != 2'd0)
                return 1'b0;
            if (elapsed < count[t]) begin
                count[t] = count[t] - elapsed;
                return 1'b0;
            end
            flag[t] = 1'b1;
            if (one_shot[t]) begin
                running[t] = 1'b0;
                count[t]   = '0;
            end else begin
                count[t] = latch[t];
            end
            return irq_en[t];
        endfunction

        function void control(int t, logic [7:0] v, logic [1:0] src);
            running[t] = v[CTRL_RUN_BIT];
            source[t]  = src;
            if (v[CTRL_LOAD_BIT])
                count[t] = latch[t];
        endfunction

        function void bus_write(logic [3:0] addr, logic [7:0] v);
            case (addr)
                ADDR_A_LO: latch[0][7:0]  = v;
                ADDR_A_HI: latch[0][15:8] = v;
                ADDR_B_LO: latch[1][7:0]  = v;
                ADDR_B_HI: latch[1][15:8] = v;
                ADDR_ICR: begin
                    if (v[ICR_SEL_A_BIT])
                        irq_en[0] = v[ICR_SET_BIT];
                    if (v[ICR_SEL_B_BIT])
                        irq_en[1] = v[ICR_SET_BIT];
                end
                ADDR_CTRL_A: control(0, v, {1'b0, v[CTRL_SRC_LSB]});
                ADDR_CTRL_B: control(1, v, v[CTRL_SRC_LSB +: 2]);
                default: ;
            endcase
        endfunction

        function logic [7:0] bus_read(logic [3:0] addr);
            case (addr)
                ADDR_A_LO: return count[0][7:0];
                ADDR_A_HI: return count[0][15:8];
                ADDR_B_LO: return count[1][7:0];
                ADDR_B_HI: return count[1][15:8];
                ADDR_ICR:  return {6'd0, flag[1], flag[0]};
                default:   return 8'd0;
            endcase
        endfunction

        // Apply one accepted transaction and queue the reply it must produce.
        function void note_access(t_in_item it);
            t_out_item reply;
            logic      irq_a;
            logic      irq_b;
            reply = '0;
            case (it.func)
                FUNC_WRITE: bus_write(it.reg_addr, it.write_data);
                FUNC_READ:  reply.read_data = bus_read(it.reg_addr);
                FUNC_TICK: begin
                    irq_a = advance(0, it.elapsed_cycles);
                    irq_b = advance(1, it.elapsed_cycles);
                    reply.irq_pulse = irq_a | irq_b;
                end
                default: ;
            endcase
            expected_replies.push_back(reply);
        endfunction

        // Compare one accepted reply with the oldest queued one.
        function void check_reply(t_out_item got);
            t_out_item want;
            if (expected_replies.size() == 0) begin
                $error("reply with no transaction outstanding: %p", got);
                fails++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
                fails++;
            end
            if (got.irq_pulse !== want.irq_pulse) begin
                $error("irq_pulse: expected %0b, actual %0b", want.irq_pulse, got.irq_pulse);
                fails++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    logic      cfg_we    = 1'b0;
    logic      cfg_idx   = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      calm      = 1'b0;

    timer_regs_model model = new();

    dual_interval_timer_regs u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_data     (in_data),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_data     (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Random backpressure on the reply channel, none during the calm phase.
    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 16);
    end

    // Check every reply transaction as it is taken.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            model.check_reply(out_data);
    end

    // Offer one transaction, with random idle cycles ahead of it.
    task automatic send_access(t_in_item it);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 16) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model.note_access(it);
    endtask

    // Stop sending and wait until every queued reply has been taken.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (model.expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(logic idx, logic val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        model.one_shot[int'(idx)] = val;
    endtask

    function automatic t_in_item access(logic [1:0] func, logic [3:0] addr,
                                        logic [7:0] data, logic [15:0] elapsed);
        t_in_item it;
        it.func           = func;
        it.reg_addr       = addr;
        it.write_data     = data;
        it.elapsed_cycles = elapsed;
        return it;
    endfunction

    function automatic logic [3:0] pick_reg();
        case ($urandom_range(0, 6))
            0:       return ADDR_A_LO;
            1:       return ADDR_A_HI;
            2:       return ADDR_B_LO;
            3:       return ADDR_B_HI;
            4:       return ADDR_ICR;
            5:       return ADDR_CTRL_A;
            default: return ADDR_CTRL_B;
        endcase
    endfunction

    // Mostly meaningful bus traffic: short latches, small ticks, running
    // timers on processor cycles. The rest is arbitrary.
    function automatic t_in_item random_access();
        t_in_item it;
        int       pick;
        it   = 30'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.func = FUNC_TICK;
            if ($urandom_range(0, 9) != 0)
                it.elapsed_cycles = 16'($urandom_range(0, 400));
        end else if (pick < 65) begin
            it.func = FUNC_READ;
            if ($urandom_range(0, 4) != 0)
                it.reg_addr = pick_reg();
        end else if (pick < 97) begin
            it.func = FUNC_WRITE;
            if ($urandom_range(0, 7) != 0)
                it.reg_addr = pick_reg();
            case (it.reg_addr)
                ADDR_A_HI, ADDR_B_HI: begin
                    if ($urandom_range(0, 3) != 0)
                        it.write_data = 8'($urandom_range(0, 1));
                end
                ADDR_CTRL_A, ADDR_CTRL_B: begin
                    if ($urandom_range(0, 3) != 0) begin
                        it.write_data[CTRL_SRC_LSB +: 2] = 2'b00;
                        it.write_data[CTRL_RUN_BIT]      = 1'b1;
                    end
                end
                default: ;
            endcase
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    // Directed opening: reload, underflow, other sources, unused registers,
    // the unused function code and a timer sitting at zero.
    t_in_item opening [$];

    initial begin
        logic mode_a;
        logic mode_b;
        opening = '{
            access(FUNC_READ,   ADDR_A_LO,   8'h00, 16'h0000),
            access(FUNC_TICK,   ADDR_A_LO,   8'h00, 16'h0000),
            access(FUNC_WRITE,  ADDR_A_LO,   8'hff, 16'h0000),
            access(FUNC_WRITE,  ADDR_A_HI,   8'h00, 16'h0000),
            access(FUNC_WRITE,  ADDR_ICR,    8'h81, 16'h0000),
            access(FUNC_WRITE,  ADDR_CTRL_A, 8'h11, 16'h0000),
            access(FUNC_TICK,   ADDR_A_LO,   8'h00, 16'h00fe),
            access(FUNC_READ,   ADDR_A_LO,   8'h00, 16'h0000),
            access(FUNC_TICK,   ADDR_A_LO,   8'h00, 16'h0001),
            access(FUNC_READ,   ADDR_ICR,    8'h00, 16'h0000),
            access(FUNC_WRITE,  ADDR_B_LO,   8'h00, 16'h0000),
            access(FUNC_WRITE,  ADDR_B_HI,   8'hff, 16'h0000),
            access(FUNC_WRITE,  ADDR_CTRL_B, 8'h71, 16'h0000),
            access(FUNC_TICK,   ADDR_A_LO,   8'h00, 16'hffff),
            access(FUNC_READ,   ADDR_B_HI,   8'h00, 16'h0000),
            access(FUNC_WRITE,  ADDR_CTRL_B, 8'h01, 16'h0000),
            access(FUNC_TICK,   ADDR_A_LO,   8'h00, 16'hffff),
            access(FUNC_WRITE,  ADDR_UNUSED, 8'haa, 16'h0000),
            access(FUNC_READ,   ADDR_UNUSED, 8'h00, 16'h0000),
            access(FUNC_UNUSED, ADDR_CTRL_B, 8'hff, 16'hffff),
            access(FUNC_WRITE,  ADDR_A_LO,   8'h00, 16'h0000),
            access(FUNC_WRITE,  ADDR_CTRL_A, 8'h11, 16'h0000),
            access(FUNC_TICK,   ADDR_A_LO,   8'h00, 16'h0000),
            access(FUNC_WRITE,  ADDR_ICR,    8'h7f, 16'h0000),
            access(FUNC_TICK,   ADDR_A_LO,   8'h00, 16'h0000)
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Each phase waits for the block to go idle, sets both modes, then runs.
        for (int phase = 0; phase < 5; phase++) begin
            drain();
            calm = (phase == 2);
            case (phase)
                0: begin mode_a = 1'b0; mode_b = 1'b0; end
                1: begin mode_a = 1'b1; mode_b = 1'b1; end
                2: begin mode_a = 1'b0; mode_b = 1'b1; end
                3: begin mode_a = 1'b1; mode_b = 1'b0; end
                default: begin
                    mode_a = 1'($urandom_range(0, 1));
                    mode_b = 1'($urandom_range(0, 1));
                end
            endcase
            write_mode(CFG_FIRST_ONE_SHOT, mode_a);
            write_mode(CFG_SECOND_ONE_SHOT, mode_b);
            if (phase == 0) begin
                foreach (opening[i])
                    send_access(opening[i]);
            end
            repeat (200) send_access(random_access());
        end
        drain();
        repeat (10) @(posedge clk);

        if (model.fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a missing reply.
    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
src/dit_pkg.sv
src/dit_timer.sv
src/dual_interval_timer_regs.sv
tb/sv/dual_interval_timer_regs_tb.sv
